// ===== sv/b64e_pkg.sv =====
// Shared types, constants and the alphabet function of the base64 stream encoder.
// No dependencies; the front, queue, back and top files refer to this package by scope.
package b64e_pkg;

	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned SEXTETS     = 4;

	localparam logic [7:0] PAD_CHAR = 8'h3D;

	// One complete group as the front hands it over: four sextets, first one at
	// index zero, how many trailing characters are padding, and whether it ends
	// the stream.
	typedef struct packed {
		logic [SEXTETS-1:0][5:0] sext;
		logic [1:0]              pad;
		logic                    last;
	} group_t;

	typedef struct packed {
		logic full;
		logic empty;
	} queue_stat_t;

	function automatic logic [7:0] b64_char(input logic [5:0] v);
		logic [7:0] c;
		c = 8'h00;
		case (v) inside
			[6'd0:6'd25]:  c = 8'h41 + {2'b00, v};
			[6'd26:6'd51]: c = 8'h47 + {2'b00, v};
			[6'd52:6'd61]: c = {2'b00, v} - 8'd4;
			6'd62:         c = 8'h2B;
			default:       c = 8'h2F;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/b64e_if.sv =====
// Handshake channels of the base64 stream encoder: raw bytes in, characters out.
// Stand-alone interfaces; no package dependency.
interface b64e_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source(output valid, output data_byte, output last_byte, input ready);
	modport sink(input valid, input data_byte, input last_byte, output ready);
endinterface

interface b64e_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       group_end;
	logic       stream_end;

	modport source(output valid, output out_char, output group_end, output stream_end,
		input ready);
	modport sink(input valid, input out_char, input group_end, input stream_end,
		output ready);
endinterface

// ===== sv/b64e_front.sv =====
// Front end: accepts bytes, keeps the open group and pushes completed groups as sextets.
// Depends on b64e_pkg and b64e_byte_if.
module b64e_front (
	input  logic                  clk,
	input  logic                  arst_n,
	b64e_byte_if.sink             plain_data,
	input  b64e_pkg::queue_stat_t stat,
	output logic                  push,
	output b64e_pkg::group_t      push_group
);

	logic [7:0] held0_q;
	logic [7:0] held1_q;
	logic [1:0] cnt_q;
	logic [1:0] cnt;
	logic       accept;
	logic [7:0] b0;
	logic [7:0] b1;
	logic [7:0] b2;

	// A count of three cannot arise; it is folded onto zero.
	assign cnt    = (cnt_q == 2'd3) ? 2'd0 : cnt_q;
	assign plain_data.ready = !stat.full;
	assign accept = plain_data.valid && !stat.full;
	assign push   = accept && (plain_data.last_byte || cnt == 2'd2);

	always_comb begin
		b0 = plain_data.data_byte;
		b1 = 8'h00;
		b2 = 8'h00;
		push_group.pad = 2'd2;
		case (cnt)
			2'd1: begin
				b0 = held0_q;
				b1 = plain_data.data_byte;
				push_group.pad = 2'd1;
			end
			2'd2: begin
				b0 = held0_q;
				b1 = held1_q;
				b2 = plain_data.data_byte;
				push_group.pad = 2'd0;
			end
			default: begin
			end
		endcase
		push_group.sext[0] = b0[7:2];
		push_group.sext[1] = {b0[1:0], b1[7:4]};
		push_group.sext[2] = {b1[3:0], b2[7:6]};
		push_group.sext[3] = b2[5:0];
		push_group.last    = plain_data.last_byte;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (accept) begin
			cnt_q <= push ? 2'd0 : cnt + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && !push) begin
			if (cnt == 2'd0) begin
				held0_q <= plain_data.data_byte;
			end else begin
				held1_q <= plain_data.data_byte;
			end
		end
	end

endmodule

// ===== sv/b64e_queue.sv =====
// Short group queue between the front and the back of the encoder.
// Depends on b64e_pkg for the group type and the status struct.
module b64e_queue #(
	parameter int unsigned DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  b64e_pkg::group_t      push_group,
	input  logic                  pop,
	output b64e_pkg::group_t      head,
	output b64e_pkg::queue_stat_t stat
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	b64e_pkg::group_t slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign stat.full  = (cnt_q == CNT_W'(DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign do_push    = push && !stat.full;
	assign do_pop     = pop && !stat.empty;
	assign head       = slot_q[rd_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= next_ptr(wr_q);
			end
			if (do_pop) begin
				rd_q <= next_ptr(rd_q);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= push_group;
		end
	end

endmodule

// ===== sv/b64e_back.sv =====
// Back end: takes one group at a time from the queue and sends its four characters.
// Depends on b64e_pkg and b64e_char_if.
module b64e_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  b64e_pkg::group_t      head,
	input  b64e_pkg::queue_stat_t stat,
	output logic                  pop,
	b64e_char_if.source           coded_chars
);

	b64e_pkg::group_t cur_q;
	logic             cur_valid_q;
	logic [1:0]       idx_q;
	logic             out_valid_q;
	logic [7:0]       char_q;
	logic             gend_q;
	logic             send_q;
	logic             advance;
	logic             at_end;
	logic             is_pad;

	assign advance = cur_valid_q && (!out_valid_q || coded_chars.ready);
	assign at_end  = (idx_q == 2'd3);
	assign pop     = !stat.empty && (!cur_valid_q || (advance && at_end));
	// The trailing pad characters of a short group are '='.
	assign is_pad  = ({1'b0, idx_q} >= (3'd4 - {1'b0, cur_q.pad}));

	assign coded_chars.valid      = out_valid_q;
	assign coded_chars.out_char   = char_q;
	assign coded_chars.group_end  = gend_q;
	assign coded_chars.stream_end = send_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_valid_q <= 1'b0;
			idx_q       <= 2'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				cur_valid_q <= 1'b1;
				idx_q       <= 2'd0;
			end else if (advance) begin
				idx_q <= idx_q + 2'd1;
				if (at_end) begin
					cur_valid_q <= 1'b0;
				end
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (coded_chars.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= head;
		end
		if (advance) begin
			char_q <= is_pad ? b64e_pkg::PAD_CHAR : b64e_pkg::b64_char(cur_q.sext[idx_q]);
			gend_q <= at_end;
			send_q <= at_end && cur_q.last;
		end
	end

	a_stream_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		coded_chars.valid && coded_chars.stream_end |-> coded_chars.group_end)
		else $error("stream end flagged off a group boundary");

	a_idx_needs_group: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd0 |-> cur_valid_q)
		else $error("character index advanced without a group in hand");

	a_idx_holds: assert property (@(posedge clk) disable iff (!arst_n)
		cur_valid_q && !advance && !pop |=> $stable(idx_q))
		else $error("character index moved while the output stalled");

	a_pop_on_boundary: assert property (@(posedge clk) disable iff (!arst_n)
		pop && cur_valid_q |-> at_end && advance)
		else $error("new group loaded before the current one finished");

endmodule

// ===== sv/base64_stream_encoder_unit.sv =====
// Base64 (standard alphabet) stream encoder. One byte word is taken per cycle while
// the two-entry group queue has room; each completed group, or a short group closed
// by a byte marked last, leaves as four character words, one per cycle while the
// character port is ready, with '=' padding for short groups. The character port
// sets the sustained rate; a byte that completes a group passes the queue slot, the
// group register and the character register before its first character shows. The
// input stalls only when the queue is full while the back end drains earlier groups.
module base64_stream_encoder_unit #(
	parameter int unsigned QUEUE_DEPTH = b64e_pkg::QUEUE_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	b64e_byte_if.sink   plain_data,
	b64e_char_if.source coded_chars
);

	logic                  push;
	logic                  pop;
	b64e_pkg::group_t      push_group;
	b64e_pkg::group_t      head;
	b64e_pkg::queue_stat_t stat;

	b64e_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.plain_data (plain_data),
		.stat       (stat),
		.push       (push),
		.push_group (push_group)
	);

	b64e_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_group (push_group),
		.pop        (pop),
		.head       (head),
		.stat       (stat)
	);

	b64e_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.stat        (stat),
		.pop         (pop),
		.coded_chars (coded_chars)
	);

endmodule
